### design/thsr_pkg.sv
package thsr_pkg;

   localparam int WORD_BITS_WIDTH = 7;
   localparam int WAIT_WIDTH = 16;
   localparam int WORD_WIDTH = 64;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH = 16;

   localparam logic [WORD_BITS_WIDTH-1:0] WORD_BITS_RESET = 7'd8;
   localparam logic [WAIT_WIDTH-1:0] WAIT_LIMIT_RESET = 16'd0;
   localparam logic [WAIT_WIDTH-1:0] WAIT_COUNT_MAX = 16'hFFFF;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_WORD_BITS  = 1'b0,
      CSR_WAIT_LIMIT = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      EVENT_NONE       = 2'd0,
      EVENT_WORD       = 2'd1,
      EVENT_TIMEOUT    = 2'd2,
      EVENT_TERM_ERROR = 2'd3
   } event_type;

   typedef struct packed {
      logic tx_level;
      logic data_level;
   } req_payload_type;

   typedef struct packed {
      logic                  rx_level;
      event_type             event_res;
      logic [WORD_WIDTH-1:0] word;
   } rsp_payload_type;

endpackage

### design/thsr_stream_if.sv
interface thsr_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

### design/toggle_handshake_serial_receiver_core.sv
// Channel   Direction  Payload                          Handshake
// req_*     in         tx_level, data_level              valid / ready
// rsp_*     out        rx_level, event_res, word         valid / ready
// csr_*     in         word_bits (0), wait_limit (1)     write enable only
//
// Every accepted request produces exactly one response, presented in the next
// cycle when the response register is free; a response accepted behind a stalled one waits in the skid register.
// A request can be accepted in every clock cycle while the skid register is empty;
// the single state update feeds the response register directly.
// A two-entry output stage (response register plus skid register) keeps
// req_ready independent of rsp_ready; req_ready drops only when both are full.
// Reset is synchronous and active high; word_bits returns to 8, wait_limit to 0.
module toggle_handshake_serial_receiver_core
   import thsr_pkg::*;
#(
   parameter int MAX_WORD_BITS = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   thsr_stream_if.sink                req_stream,
   thsr_stream_if.source              rsp_stream,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   localparam logic [WORD_BITS_WIDTH-1:0] MAX_LEN = WORD_BITS_WIDTH'(MAX_WORD_BITS);
   localparam logic [WORD_BITS_WIDTH-1:0] MIN_LEN = WORD_BITS_WIDTH'(1);

   logic [WORD_BITS_WIDTH-1:0] word_bits_ff;
   logic [WAIT_WIDTH-1:0]      wait_limit_ff;

   logic                       tx_last_ff;
   logic                       tx_last_in;
   logic                       rx_last_ff;
   logic                       rx_last_in;
   logic [WORD_BITS_WIDTH-1:0] bit_position_ff;
   logic [WORD_BITS_WIDTH-1:0] bit_position_in;
   logic [WAIT_WIDTH-1:0]      wait_count_ff;
   logic [WAIT_WIDTH-1:0]      wait_count_in;
   logic [MAX_WORD_BITS-1:0]   word_shift_ff;
   logic [MAX_WORD_BITS-1:0]   word_shift_in;

   logic                       out_valid_ff;
   rsp_payload_type            out_data_ff;
   logic                       skid_valid_ff;
   rsp_payload_type            skid_data_ff;

   logic                       accept;
   logic                       out_free;
   logic [WORD_BITS_WIDTH-1:0] eff_len;
   logic [WORD_BITS_WIDTH-1:0] next_position;
   logic [MAX_WORD_BITS-1:0]   captured;
   logic [WAIT_WIDTH-1:0]      wait_inc;
   rsp_payload_type            result;

   assign req_stream.ready = !skid_valid_ff;
   assign accept = req_stream.valid && !skid_valid_ff;
   assign out_free = !out_valid_ff || rsp_stream.ready;

   assign rsp_stream.valid = out_valid_ff;
   assign rsp_stream.payload = out_data_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         word_bits_ff <= WORD_BITS_RESET;
         wait_limit_ff <= WAIT_LIMIT_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_WORD_BITS: begin
               word_bits_ff <= csr_wdata[WORD_BITS_WIDTH-1:0];
            end
            CSR_WAIT_LIMIT: begin
               wait_limit_ff <= csr_wdata[WAIT_WIDTH-1:0];
            end
         endcase
      end
   end

   always_comb begin
      if (word_bits_ff < MIN_LEN) begin
         eff_len = MIN_LEN;
      end else if (word_bits_ff > MAX_LEN) begin
         eff_len = MAX_LEN;
      end else begin
         eff_len = word_bits_ff;
      end
   end

   assign next_position = bit_position_ff + WORD_BITS_WIDTH'(1);
   assign captured = word_shift_ff
                     | (MAX_WORD_BITS'(req_stream.payload.data_level) << bit_position_ff);
   assign wait_inc = (wait_count_ff == WAIT_COUNT_MAX) ? wait_count_ff
                                                       : wait_count_ff + WAIT_WIDTH'(1);

   // One tick of the receiver.
   always_comb begin
      tx_last_in = tx_last_ff;
      rx_last_in = rx_last_ff;
      bit_position_in = bit_position_ff;
      wait_count_in = wait_count_ff;
      word_shift_in = word_shift_ff;
      result.event_res = EVENT_NONE;
      result.word = '0;
      if (req_stream.payload.tx_level != tx_last_ff) begin
         tx_last_in = req_stream.payload.tx_level;
         rx_last_in = !rx_last_ff;
         wait_count_in = '0;
         bit_position_in = next_position;
         word_shift_in = captured;
         if (next_position >= eff_len) begin
            if (!rx_last_in) begin
               result.event_res = EVENT_WORD;
               result.word = WORD_WIDTH'(captured);
            end else begin
               result.event_res = EVENT_TERM_ERROR;
            end
            bit_position_in = '0;
            word_shift_in = '0;
         end
      end else begin
         wait_count_in = wait_inc;
         if (wait_limit_ff != '0 && wait_inc >= wait_limit_ff) begin
            result.event_res = EVENT_TIMEOUT;
            wait_count_in = '0;
         end
      end
      result.rx_level = rx_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tx_last_ff <= 1'b0;
         rx_last_ff <= 1'b0;
         bit_position_ff <= '0;
         wait_count_ff <= '0;
         word_shift_ff <= '0;
      end else if (accept) begin
         tx_last_ff <= tx_last_in;
         rx_last_ff <= rx_last_in;
         bit_position_ff <= bit_position_in;
         wait_count_ff <= wait_count_in;
         word_shift_ff <= word_shift_in;
      end
   end

   // Output stage control.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_ff <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= accept;
         end
      end else if (accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   // Output stage data.
   always_ff @(posedge clock) begin
      if (out_free) begin
         if (skid_valid_ff) begin
            out_data_ff <= skid_data_ff;
         end else if (accept) begin
            out_data_ff <= result;
         end
      end else if (accept) begin
         skid_data_ff <= result;
      end
   end

endmodule

### design/thsr_checker.sv
module thsr_checker
   import thsr_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [1:0]            rsp_event_res,
   input logic [WORD_WIDTH-1:0] rsp_word
);

   // The skid register can only be occupied while a response is pending.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request side stalled with no response pending");

   // The word carries data only for a complete word.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_res != EVENT_WORD |-> rsp_word == '0)
      else $error("nonzero word on a response that is not a complete word");

   // After an accepted request, a response is always valid in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted request produced no response");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_event_res) && $stable(rsp_word))
      else $error("stalled response changed");

endmodule

bind toggle_handshake_serial_receiver_core thsr_checker u_thsr_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_stream.valid),
   .req_ready     (req_stream.ready),
   .rsp_valid     (rsp_stream.valid),
   .rsp_ready     (rsp_stream.ready),
   .rsp_event_res (rsp_stream.payload.event_res),
   .rsp_word      (rsp_stream.payload.word)
);
